// File: rtl/core/ast_pkg.sv
// Shared types and constants for the assembly source tokenizer.
`timescale 1ns / 1ps

package ast_pkg;

    localparam int NUMBER_WIDTH = 32;
    localparam int NUM_OUT_W    = 32;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_NEWLINE  = 8'h0a;
    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_HASH     = 8'h23;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_MINUS    = 8'h2d;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3b;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5a;
    localparam logic [7:0] CH_LBRACKET = 8'h5b;
    localparam logic [7:0] CH_BSLASH   = 8'h5c;
    localparam logic [7:0] CH_RBRACKET = 8'h5d;
    localparam logic [7:0] CH_UNDER    = 8'h5f;
    localparam logic [7:0] CH_LO_A     = 8'h61;
    localparam logic [7:0] CH_LO_C     = 8'h63;
    localparam logic [7:0] CH_LO_F     = 8'h66;
    localparam logic [7:0] CH_LO_H     = 8'h68;
    localparam logic [7:0] CH_LO_L     = 8'h6c;
    localparam logic [7:0] CH_LO_N     = 8'h6e;
    localparam logic [7:0] CH_LO_P     = 8'h70;
    localparam logic [7:0] CH_LO_S     = 8'h73;
    localparam logic [7:0] CH_LO_X     = 8'h78;
    localparam logic [7:0] CH_LO_Z     = 8'h7a;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    localparam logic [3:0] REG_NONE = 4'd0;
    localparam logic [3:0] REG_PC   = 4'd8;
    localparam logic [3:0] REG_SP   = 4'd9;

    typedef enum logic [3:0] {
        M_IDLE,
        M_STR,
        M_SYM,
        M_COMMENT,
        M_ZERO,
        M_DEC,
        M_HEX,
        M_HASH,
        M_HASH_P,
        M_HASH_S,
        M_HASH_BS,
        M_CHAR_N
    } mode_t;

    typedef enum logic [3:0] {
        K_LPAREN,
        K_LBRACKET,
        K_RPAREN,
        K_RBRACKET,
        K_STRING,
        K_SYMBOL,
        K_NUMBER,
        K_REGISTER,
        K_CHAR,
        K_ERROR,
        K_END
    } kind_t;

    typedef struct packed {
        kind_t                 kind;
        logic [7:0]            piece_char;
        logic                  has_char;
        logic                  piece_last;
        logic [NUM_OUT_W-1:0]  number_value;
        logic [3:0]            register_code;
        logic                  last;
    } tok_t;

    typedef struct packed {
        logic [1:0] count;
        tok_t       r0;
        tok_t       r1;
    } step_t;

endpackage

// File: rtl/core/ast_lexer.sv
// Lexer state registers and the per-byte next-state and token logic.
`timescale 1ns / 1ps

module ast_lexer (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step_en,
    input  logic [7:0]    text_byte,
    output ast_pkg::step_t step
);
    import ast_pkg::*;

    mode_t                   mode_reg, mode_next;
    logic [7:0]              held_char_reg, held_char_next;
    logic                    held_valid_reg, held_valid_next;
    logic [NUMBER_WIDTH-1:0] acc_reg, acc_next;
    logic                    hex_flag_reg, hex_flag_next;

    function automatic tok_t mk(input kind_t k, input logic [7:0] ch, input logic has,
                                input logic pl, input logic [NUM_OUT_W-1:0] num,
                                input logic [3:0] rc);
        tok_t t;
        t.kind          = k;
        t.piece_char    = ch;
        t.has_char      = has;
        t.piece_last    = pl;
        t.number_value  = num;
        t.register_code = rc;
        t.last          = 1'b0;
        return t;
    endfunction

    always_comb
    begin
        tok_t       a;
        tok_t       s;
        logic       a_v;
        logic       s_v;
        logic       run_start;
        logic [7:0] b;
        logic [7:0] c;
        logic       is_alpha;
        logic       is_dec;
        logic       dok;
        logic [3:0] dval;

        b = text_byte;
        c = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFFSET : b;
        is_alpha = (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
        is_dec = (b >= CH_ZERO && b <= CH_NINE);
        if (is_dec)
        begin
            dok  = 1'b1;
            dval = b[3:0];
        end
        else if (hex_flag_reg && c >= CH_LO_A && c <= CH_LO_F)
        begin
            dok  = 1'b1;
            dval = c[3:0] + 4'd9;
        end
        else
        begin
            dok  = 1'b0;
            dval = 4'd0;
        end

        mode_next       = mode_reg;
        held_char_next  = held_char_reg;
        held_valid_next = held_valid_reg;
        acc_next        = acc_reg;
        hex_flag_next   = hex_flag_reg;
        a         = '0;
        s         = '0;
        a_v       = 1'b0;
        s_v       = 1'b0;
        run_start = 1'b0;

        case (mode_reg)
            M_IDLE:
            begin
                run_start = 1'b1;
            end
            M_STR:
            begin
                if (b == CH_QUOTE || b == CH_NUL)
                begin
                    a = mk(K_STRING, held_valid_reg ? held_char_reg : CH_NUL,
                           held_valid_reg, 1'b1, '0, REG_NONE);
                    a_v             = 1'b1;
                    held_valid_next = 1'b0;
                    mode_next       = M_IDLE;
                    run_start       = (b == CH_NUL);
                end
                else
                begin
                    a   = mk(K_STRING, held_char_reg, 1'b1, 1'b0, '0, REG_NONE);
                    a_v = held_valid_reg;
                    held_char_next  = b;
                    held_valid_next = 1'b1;
                end
            end
            M_SYM:
            begin
                if (is_alpha || is_dec || b == CH_UNDER || b == CH_MINUS)
                begin
                    a   = mk(K_SYMBOL, held_char_reg, 1'b1, 1'b0, '0, REG_NONE);
                    a_v = 1'b1;
                    held_char_next = b;
                end
                else
                begin
                    a   = mk(K_SYMBOL, held_char_reg, 1'b1, 1'b1, '0, REG_NONE);
                    a_v = 1'b1;
                    held_valid_next = 1'b0;
                    mode_next       = M_IDLE;
                    run_start       = 1'b1;
                end
            end
            M_COMMENT:
            begin
                if (b == CH_NEWLINE || b == CH_NUL)
                begin
                    mode_next = M_IDLE;
                    run_start = (b == CH_NUL);
                end
            end
            M_ZERO, M_DEC, M_HEX:
            begin
                if (mode_reg == M_ZERO && b == CH_LO_X)
                begin
                    mode_next     = M_HEX;
                    hex_flag_next = 1'b1;
                    acc_next      = '0;
                end
                else if (dok)
                begin
                    if (hex_flag_reg)
                        acc_next = {acc_reg[NUMBER_WIDTH-5:0], dval};
                    else
                        acc_next = (acc_reg << 3) + (acc_reg << 1) + NUMBER_WIDTH'(dval);
                    if (mode_reg == M_ZERO)
                        mode_next = M_DEC;
                end
                else
                begin
                    a   = mk(K_NUMBER, CH_NUL, 1'b0, 1'b0, NUM_OUT_W'(acc_reg), REG_NONE);
                    a_v = 1'b1;
                    acc_next      = '0;
                    hex_flag_next = 1'b0;
                    mode_next     = M_IDLE;
                    run_start     = 1'b1;
                end
            end
            M_HASH:
            begin
                mode_next = M_IDLE;
                if (c >= CH_LO_A && c <= CH_LO_H)
                begin
                    a   = mk(K_REGISTER, CH_NUL, 1'b0, 1'b0, '0, 4'(c - CH_LO_A));
                    a_v = 1'b1;
                end
                else if (c == CH_LO_P)
                    mode_next = M_HASH_P;
                else if (c == CH_LO_S)
                    mode_next = M_HASH_S;
                else if (c == CH_BSLASH)
                    mode_next = M_HASH_BS;
                else
                begin
                    a   = mk(K_ERROR, CH_NUL, 1'b0, 1'b0, '0, REG_NONE);
                    a_v = 1'b1;
                    run_start = (b == CH_NUL);
                end
            end
            M_HASH_P:
            begin
                a   = mk(K_REGISTER, CH_NUL, 1'b0, 1'b0, '0,
                         (c == CH_LO_C) ? REG_PC : REG_NONE);
                a_v = 1'b1;
                mode_next = M_IDLE;
                run_start = (b == CH_NUL);
            end
            M_HASH_S:
            begin
                a   = mk(K_REGISTER, CH_NUL, 1'b0, 1'b0, '0,
                         (c == CH_LO_P) ? REG_SP : REG_NONE);
                a_v = 1'b1;
                mode_next = M_IDLE;
                run_start = (b == CH_NUL);
            end
            M_HASH_BS:
            begin
                if (c == CH_LO_N)
                begin
                    held_char_next = b;
                    mode_next      = M_CHAR_N;
                end
                else
                begin
                    a   = mk(K_CHAR, b, 1'b1, 1'b0, '0, REG_NONE);
                    a_v = 1'b1;
                    mode_next = M_IDLE;
                    run_start = (b == CH_NUL);
                end
            end
            M_CHAR_N:
            begin
                mode_next = M_IDLE;
                a_v = 1'b1;
                if (c == CH_LO_L)
                    a = mk(K_CHAR, CH_NEWLINE, 1'b1, 1'b0, '0, REG_NONE);
                else
                begin
                    a = mk(K_CHAR, held_char_reg, 1'b1, 1'b0, '0, REG_NONE);
                    run_start = 1'b1;
                end
            end
            default:
            begin
                mode_next = M_IDLE;
                run_start = 1'b1;
            end
        endcase

        // A byte that ended a token without being part of it, or any byte seen from idle, may open a new one.
        if (run_start)
        begin
            case (b)
                CH_NUL:
                begin
                    s   = mk(K_END, CH_NUL, 1'b0, 1'b0, '0, REG_NONE);
                    s_v = 1'b1;
                end
                CH_LPAREN:
                begin
                    s   = mk(K_LPAREN, CH_NUL, 1'b0, 1'b0, '0, REG_NONE);
                    s_v = 1'b1;
                end
                CH_LBRACKET:
                begin
                    s   = mk(K_LBRACKET, CH_NUL, 1'b0, 1'b0, '0, REG_NONE);
                    s_v = 1'b1;
                end
                CH_RPAREN:
                begin
                    s   = mk(K_RPAREN, CH_NUL, 1'b0, 1'b0, '0, REG_NONE);
                    s_v = 1'b1;
                end
                CH_RBRACKET:
                begin
                    s   = mk(K_RBRACKET, CH_NUL, 1'b0, 1'b0, '0, REG_NONE);
                    s_v = 1'b1;
                end
                CH_QUOTE:
                begin
                    mode_next       = M_STR;
                    held_valid_next = 1'b0;
                end
                CH_SEMI:
                begin
                    mode_next = M_COMMENT;
                end
                CH_HASH:
                begin
                    mode_next = M_HASH;
                end
                default:
                begin
                    if (is_alpha)
                    begin
                        mode_next       = M_SYM;
                        held_char_next  = b;
                        held_valid_next = 1'b1;
                    end
                    else if (is_dec)
                    begin
                        mode_next     = (b == CH_ZERO) ? M_ZERO : M_DEC;
                        acc_next      = NUMBER_WIDTH'(b[3:0]);
                        hex_flag_next = 1'b0;
                    end
                end
            endcase
        end

        if (a_v && s_v)
        begin
            step.count = 2'd2;
            step.r0    = a;
            step.r1    = s;
        end
        else
        begin
            step.count = {1'b0, a_v | s_v};
            step.r0    = a_v ? a : s;
            step.r1    = '0;
        end
        step.r0.last = (step.count == 2'd1);
        step.r1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= M_IDLE;
            held_char_reg  <= '0;
            held_valid_reg <= 1'b0;
            acc_reg        <= '0;
            hex_flag_reg   <= 1'b0;
        end
        else if (step_en)
        begin
            mode_reg       <= mode_next;
            held_char_reg  <= held_char_next;
            held_valid_reg <= held_valid_next;
            acc_reg        <= acc_next;
            hex_flag_reg   <= hex_flag_next;
        end
    end

`ifndef SYNTH
    a_hex_only_in_hex_mode: assert property (@(posedge clk) disable iff (!rst_n)
        hex_flag_reg |-> mode_reg == M_HEX)
        else $error("hex flag set outside hex number mode");

    a_char_n_holds_n: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == M_CHAR_N |-> (held_char_reg | CASE_OFFSET) == CH_LO_N)
        else $error("pending character literal does not hold an n");
`endif

endmodule

// File: rtl/core/assembly_source_tokenizer_core.sv
// Top level of the assembly source tokenizer: lexer step and result queue.
`timescale 1ns / 1ps
// Each byte gives up to two tokens, put into the result queue whose head drives the outputs.
// Throughput: one byte per cycle while in_ready; tokens drain one per cycle while out_ready.
// A four-entry result queue lets input continue while results wait; in_ready needs two free.
// Reset is asynchronous and active low: the lexer returns to idle and the queue empties.

module assembly_source_tokenizer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  text_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  kind,
    output logic [7:0]  piece_char,
    output logic        has_char,
    output logic        piece_last,
    output logic [31:0] number_value,
    output logic [3:0]  register_code,
    output logic        last
);
    import ast_pkg::*;

    step_t              step;
    logic               push;
    logic               pop;
    logic [1:0]         push_n;
    tok_t               mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wp_reg, wp_next;
    logic [FIFO_AW-1:0] rp_reg, rp_next;
    logic [FIFO_CW-1:0] cnt_reg, cnt_next;
    tok_t               head;

    assign in_ready  = (cnt_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign push      = in_valid && in_ready;
    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && out_ready;
    assign push_n    = push ? step.count : 2'd0;

    ast_lexer u_lexer (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (push),
        .text_byte (text_byte),
        .step      (step)
    );

    assign wp_next  = wp_reg + FIFO_AW'(push_n);
    assign rp_next  = rp_reg + FIFO_AW'(pop);
    assign cnt_next = cnt_reg + FIFO_CW'(push_n) - FIFO_CW'(pop);

    always_ff @(posedge clk)
    begin
        if (push && step.count != 2'd0)
            mem[wp_reg] <= step.r0;
        if (push && step.count == 2'd2)
            mem[wp_reg + FIFO_AW'(1)] <= step.r1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    assign head          = mem[rp_reg];
    assign kind          = head.kind;
    assign piece_char    = head.piece_char;
    assign has_char      = head.has_char;
    assign piece_last    = head.piece_last;
    assign number_value  = head.number_value;
    assign register_code = head.register_code;
    assign last          = head.last;

`ifndef SYNTH
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CW'(FIFO_DEPTH))
        else $error("result queue overfilled");

    a_queue_accounting: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> cnt_reg == $past(cnt_reg) + FIFO_CW'($past(push_n)) - FIFO_CW'($past(pop)))
        else $error("result queue count lost track of items");

    a_pointer_gap: assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_AW'(wp_reg - rp_reg) == FIFO_AW'(cnt_reg))
        else $error("queue pointers disagree with the count");
`endif

endmodule

// File: tb/tb_assembly_source_tokenizer_core.sv
// Testbench for the assembly source tokenizer core: a directed text, random source texts, token prediction, checks.
`timescale 1ns / 1ps

module tb_assembly_source_tokenizer_core;

    import ast_pkg::*;

    localparam int HOLD_FOR_DRAIN = -1;
    localparam int CALM_START     = -2;
    localparam int CALM_END       = -3;
    localparam int IDLE_PCT       = 21;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 16;

    localparam string ALPHA      = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
    localparam string SYM_CHARS  = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_-";
    localparam string DIGITS     = "0123456789";
    localparam string HEX_CHARS  = "0123456789abcdefABCDEF";
    localparam string SEPARATORS = " \n\t,";

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  text_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  kind;
    logic [7:0]  piece_char;
    logic        has_char;
    logic        piece_last;
    logic [31:0] number_value;
    logic [3:0]  register_code;
    logic        last;

    int   pending_bytes[$];
    tok_t tokens_due[$];
    tok_t byte_toks[$];
    bit   calm = 1'b0;
    bit   byte_taken = 1'b0;
    bit   failed = 1'b0;
    int   quiet_cycles = 0;

    mode_t       lex_mode = M_IDLE;
    logic [7:0]  held_byte = 8'h00;
    bit          held_ok = 1'b0;
    logic [31:0] accum = 32'h0;
    bit          in_hex = 1'b0;

    assembly_source_tokenizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .text_byte    (text_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .piece_char   (piece_char),
        .has_char     (has_char),
        .piece_last   (piece_last),
        .number_value (number_value),
        .register_code(register_code),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit is_alpha(logic [7:0] b);
        return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z);
    endfunction

    function automatic bit is_numeral(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void add_token(kind_t k, logic [7:0] ch, logic has, logic plast,
                                      logic [31:0] num, logic [3:0] rc);
        tok_t t;
        t.kind          = k;
        t.piece_char    = ch;
        t.has_char      = has;
        t.piece_last    = plast;
        t.number_value  = num;
        t.register_code = rc;
        t.last          = 1'b0;
        byte_toks.push_back(t);
    endfunction

    function automatic void start_token(logic [7:0] b);
        case (b)
            CH_NUL:      add_token(K_END, 8'h00, 1'b0, 1'b0, 32'h0, REG_NONE);
            CH_LPAREN:   add_token(K_LPAREN, 8'h00, 1'b0, 1'b0, 32'h0, REG_NONE);
            CH_LBRACKET: add_token(K_LBRACKET, 8'h00, 1'b0, 1'b0, 32'h0, REG_NONE);
            CH_RPAREN:   add_token(K_RPAREN, 8'h00, 1'b0, 1'b0, 32'h0, REG_NONE);
            CH_RBRACKET: add_token(K_RBRACKET, 8'h00, 1'b0, 1'b0, 32'h0, REG_NONE);
            CH_QUOTE:
            begin
                lex_mode = M_STR;
                held_ok  = 1'b0;
            end
            CH_SEMI:     lex_mode = M_COMMENT;
            CH_HASH:     lex_mode = M_HASH;
            default:
            begin
                if (is_alpha(b))
                begin
                    lex_mode  = M_SYM;
                    held_byte = b;
                    held_ok   = 1'b1;
                end
                else if (is_numeral(b))
                begin
                    lex_mode = (b == CH_ZERO) ? M_ZERO : M_DEC;
                    accum    = 32'(b - CH_ZERO);
                    in_hex   = 1'b0;
                end
            end
        endcase
    endfunction

    // Returns 1 when the byte closed a token and must be handled again from idle.
    function automatic bit lex_step(logic [7:0] b);
        logic [7:0] c;
        int         digit;
        c = (b >= CH_UP_A && b <= CH_UP_Z) ? b + CASE_OFFSET : b;
        if (lex_mode == M_ZERO)
        begin
            if (b == CH_LO_X)
            begin
                lex_mode = M_HEX;
                in_hex   = 1'b1;
                accum    = 32'h0;
                return 1'b0;
            end
            lex_mode = M_DEC;
        end
        case (lex_mode)
            M_IDLE:
            begin
                start_token(b);
                return 1'b0;
            end
            M_STR:
            begin
                if (b == CH_QUOTE || b == CH_NUL)
                begin
                    add_token(K_STRING, held_ok ? held_byte : 8'h00, held_ok, 1'b1, 32'h0,
                              REG_NONE);
                    held_ok  = 1'b0;
                    lex_mode = M_IDLE;
                    return b == CH_NUL;
                end
                if (held_ok)
                    add_token(K_STRING, held_byte, 1'b1, 1'b0, 32'h0, REG_NONE);
                held_byte = b;
                held_ok   = 1'b1;
                return 1'b0;
            end
            M_SYM:
            begin
                if (is_alpha(b) || is_numeral(b) || b == CH_UNDER || b == CH_MINUS)
                begin
                    add_token(K_SYMBOL, held_byte, 1'b1, 1'b0, 32'h0, REG_NONE);
                    held_byte = b;
                    return 1'b0;
                end
                add_token(K_SYMBOL, held_byte, 1'b1, 1'b1, 32'h0, REG_NONE);
                held_ok  = 1'b0;
                lex_mode = M_IDLE;
                return 1'b1;
            end
            M_COMMENT:
            begin
                if (b == CH_NEWLINE || b == CH_NUL)
                begin
                    lex_mode = M_IDLE;
                    return b == CH_NUL;
                end
                return 1'b0;
            end
            M_DEC, M_HEX:
            begin
                digit = -1;
                if (is_numeral(b))
                    digit = int'(b - CH_ZERO);
                else if (in_hex && c >= CH_LO_A && c <= CH_LO_F)
                    digit = int'(c - CH_LO_A) + 10;
                if (digit >= 0)
                begin
                    accum = accum * (in_hex ? 32'd16 : 32'd10) + 32'(digit);
                    return 1'b0;
                end
                add_token(K_NUMBER, 8'h00, 1'b0, 1'b0, accum, REG_NONE);
                accum    = 32'h0;
                in_hex   = 1'b0;
                lex_mode = M_IDLE;
                return 1'b1;
            end
            M_HASH:
            begin
                lex_mode = M_IDLE;
                if (c >= CH_LO_A && c <= CH_LO_H)
                begin
                    add_token(K_REGISTER, 8'h00, 1'b0, 1'b0, 32'h0, 4'(c - CH_LO_A));
                    return 1'b0;
                end
                if (c == CH_LO_P)
                begin
                    lex_mode = M_HASH_P;
                    return 1'b0;
                end
                if (c == CH_LO_S)
                begin
                    lex_mode = M_HASH_S;
                    return 1'b0;
                end
                if (c == CH_BSLASH)
                begin
                    lex_mode = M_HASH_BS;
                    return 1'b0;
                end
                add_token(K_ERROR, 8'h00, 1'b0, 1'b0, 32'h0, REG_NONE);
                return b == CH_NUL;
            end
            M_HASH_P:
            begin
                add_token(K_REGISTER, 8'h00, 1'b0, 1'b0, 32'h0,
                          (c == CH_LO_C) ? REG_PC : REG_NONE);
                lex_mode = M_IDLE;
                return b == CH_NUL;
            end
            M_HASH_S:
            begin
                add_token(K_REGISTER, 8'h00, 1'b0, 1'b0, 32'h0,
                          (c == CH_LO_P) ? REG_SP : REG_NONE);
                lex_mode = M_IDLE;
                return b == CH_NUL;
            end
            M_HASH_BS:
            begin
                if (c == CH_LO_N)
                begin
                    held_byte = b;
                    lex_mode  = M_CHAR_N;
                    return 1'b0;
                end
                add_token(K_CHAR, b, 1'b1, 1'b0, 32'h0, REG_NONE);
                lex_mode = M_IDLE;
                return b == CH_NUL;
            end
            M_CHAR_N:
            begin
                lex_mode = M_IDLE;
                if (c == CH_LO_L)
                begin
                    add_token(K_CHAR, CH_NEWLINE, 1'b1, 1'b0, 32'h0, REG_NONE);
                    return 1'b0;
                end
                add_token(K_CHAR, held_byte, 1'b1, 1'b0, 32'h0, REG_NONE);
                return 1'b1;
            end
            default:
            begin
                lex_mode = M_IDLE;
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void tokenize_byte(logic [7:0] b);
        byte_toks.delete();
        if (lex_step(b))
            void'(lex_step(b));
        if (byte_toks.size() > 0)
            byte_toks[byte_toks.size() - 1].last = 1'b1;
        foreach (byte_toks[i])
            tokens_due.push_back(byte_toks[i]);
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            failed = 1'b1;
        end
    endfunction

    function automatic void push_byte(logic [7:0] b);
        pending_bytes.push_back(int'(b));
    endfunction

    function automatic void push_text(string s);
        logic [7:0] ch;
        for (int i = 0; i < s.len(); i++)
        begin
            ch = s[i];
            pending_bytes.push_back(int'(ch));
        end
    endfunction

    function automatic logic [7:0] pick(string s);
        return s[$urandom_range(s.len() - 1)];
    endfunction

    function automatic logic [7:0] rand_byte_except(logic [7:0] a, logic [7:0] b);
        logic [7:0] r;
        r = a;
        while (r == a || r == b)
            r = 8'($urandom_range(1, 255));
        return r;
    endfunction

    // One source text: mostly well-formed tokens, sometimes cut off or plain noise.
    function automatic void add_text();
        if ($urandom_range(19) == 0)
        begin
            repeat ($urandom_range(4, 20))
                pending_bytes.push_back($urandom_range(255));
            push_byte(CH_NUL);
            return;
        end
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(9))
                0: push_byte(pick("([)]"));
                1:
                begin
                    push_byte(CH_QUOTE);
                    repeat ($urandom_range(6))
                        push_byte(rand_byte_except(CH_QUOTE, CH_QUOTE));
                    push_byte(CH_QUOTE);
                end
                2:
                begin
                    push_byte(pick(ALPHA));
                    repeat ($urandom_range(6))
                        push_byte(pick(SYM_CHARS));
                end
                3:
                begin
                    push_byte(pick(DIGITS));
                    repeat ($urandom_range(11))
                        push_byte(pick(DIGITS));
                end
                4:
                begin
                    push_byte(CH_ZERO);
                    push_byte(pick("xxxX"));
                    repeat ($urandom_range(10))
                        push_byte(pick(HEX_CHARS));
                end
                5:
                begin
                    push_byte(CH_HASH);
                    case ($urandom_range(3))
                        0: push_byte(pick("abcdefghABCDEFGH"));
                        1: push_text("pc");
                        2: push_text("sP");
                        default:
                        begin
                            push_byte(pick("pPsS"));
                            push_byte(rand_byte_except(CH_NUL, CH_NUL));
                        end
                    endcase
                end
                6:
                begin
                    push_text("#\\");
                    if ($urandom_range(3) == 0)
                        push_text("nl");
                    else
                        push_byte(rand_byte_except(CH_NUL, CH_NUL));
                end
                7:
                begin
                    push_byte(CH_SEMI);
                    repeat ($urandom_range(8))
                        push_byte(rand_byte_except(CH_NEWLINE, CH_NEWLINE));
                    push_byte(CH_NEWLINE);
                end
                8:
                begin
                    push_byte(CH_HASH);
                    push_byte(rand_byte_except(CH_NUL, CH_NUL));
                end
                default: push_byte(rand_byte_except(CH_NUL, CH_NUL));
            endcase
            if ($urandom_range(2) != 0)
                push_byte(pick(SEPARATORS));
        end
        if ($urandom_range(99) < 15)
        begin
            case ($urandom_range(6))
                0:
                begin
                    push_byte(CH_QUOTE);
                    push_byte(pick(ALPHA));
                end
                1:
                begin
                    push_byte(CH_SEMI);
                    push_byte(pick(ALPHA));
                end
                2: push_byte(CH_HASH);
                3: push_text("#p");
                4: push_text("#S");
                5: push_text("#\\");
                default: push_text("#\\N");
            endcase
        end
        push_byte(CH_NUL);
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || byte_taken)
        begin
            while (pending_bytes.size() > 0 && pending_bytes[0] < HOLD_FOR_DRAIN)
            begin
                calm = (pending_bytes[0] == CALM_START);
                void'(pending_bytes.pop_front());
            end
            if (pending_bytes.size() > 0 && pending_bytes[0] == HOLD_FOR_DRAIN &&
                tokens_due.size() == 0)
                void'(pending_bytes.pop_front());
            if (pending_bytes.size() > 0 && pending_bytes[0] >= 0 &&
                (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                text_byte <= 8'(pending_bytes.pop_front());
                in_valid  <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
        byte_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        tok_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (tokens_due.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual kind %0d", $time, kind);
                failed = 1'b1;
            end
            else
            begin
                want = tokens_due.pop_front();
                check_field("kind", 32'(want.kind), 32'(kind));
                check_field("piece_char", 32'(want.piece_char), 32'(piece_char));
                check_field("has_char", 32'(want.has_char), 32'(has_char));
                check_field("piece_last", 32'(want.piece_last), 32'(piece_last));
                check_field("number_value", want.number_value, number_value);
                check_field("register_code", 32'(want.register_code), 32'(register_code));
                check_field("last", 32'(want.last), 32'(last));
            end
        end
        if (rst_n && in_valid && in_ready)
        begin
            tokenize_byte(text_byte);
            byte_taken = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("assembly_source_tokenizer_core verification failed");
            $finish;
        end
    end

    initial
    begin
        push_text("([\"\"q_9-]#pc#sp#\\nl#!0x)0xfF;\n");
        push_byte(8'hff);
        push_byte(CH_NUL);
        pending_bytes.push_back(HOLD_FOR_DRAIN);
        while (pending_bytes.size() < 220)
            add_text();
        pending_bytes.push_back(HOLD_FOR_DRAIN);
        pending_bytes.push_back(CALM_START);
        while (pending_bytes.size() < 380)
            add_text();
        pending_bytes.push_back(CALM_END);
        while (pending_bytes.size() < 580)
            add_text();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_bytes.size() != 0 || in_valid || tokens_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (!failed && tokens_due.size() == 0)
            $display("assembly_source_tokenizer_core verification clean");
        else
            $display("assembly_source_tokenizer_core verification failed");
        $finish;
    end

endmodule
